// ----- hw/rtl/rrw_pkg.sv -----
// Shared types and constants of the reorder receive window.
package rrw_pkg;

	localparam int unsigned SEQ_W = 32;
	localparam int unsigned HANDLE_W = 10;
	localparam int unsigned LEN_W = 11;
	localparam int unsigned MAX_PAYLOAD = 1300;

	typedef enum logic [1:0] {
		OP_DATA = 2'd0,
		OP_ESTABLISH = 2'd1,
		OP_PING = 2'd2,
		OP_CLOSE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_DELIVER = 2'd0,
		KIND_ACK = 2'd1,
		KIND_ESTABLISHED = 2'd2,
		KIND_CLOSED = 2'd3
	} kind_t;

	typedef struct packed {
		logic [SEQ_W-1:0] key;
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0] len;
		logic wr;
		logic del;
		logic clr;
	} cell_cmd_t;

	typedef struct packed {
		logic hit;
		logic free_seen;
		logic [SEQ_W-1:0] seq;
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0] len;
	} cell_link_t;

endpackage

// ----- hw/rtl/reorder_receive_window_core.sv -----
// Top level of the reorder receive window: request sequencer and slot chain.
//
// Requests enter on s_axis: tuser carries the opcode, tdata the sequence,
// payload handle and payload length. Results leave on m_axis: tuser carries
// the result kind and the new-connection flag, tdata the delivered sequence,
// handle, length and the acknowledged value; tlast marks the final result of
// a request. A request is taken only when the previous one has issued all
// of its results.
// A request is accepted, then evaluated against all slots in one compare
// across the chain. An in-order delivery is followed by every held packet
// that drains behind it and then by its acknowledgement; a drained delivery
// appears each cycle while the receiver takes results. An oversized
// payload, or data while not connected, yields no result and frees the
// input once it has been evaluated.
// Reset clears the connection, the expected sequence and every slot valid
// bit at once; no clearing pass follows. When the receiver stalls, the
// output register holds its result and the sequencer waits, so no result is
// lost and the input stays closed until the request is finished.
module reorder_receive_window_core #(
	parameter int unsigned WINDOW = 32
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [55:0] s_axis_tdata, // seq[31:0], payload_handle[41:32], length[52:42]
	input logic [1:0] s_axis_tuser, // opcode[1:0]
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [87:0] m_axis_tdata, // out_seq[31:0], out_handle[41:32], out_len[52:42],
	// ack_value[84:53]
	output logic [2:0] m_axis_tuser, // kind[1:0], new_connection[2]
	output logic m_axis_tlast
);
	import rrw_pkg::*;

	localparam int unsigned CNT_W = $clog2(WINDOW + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DRAIN
	} state_t;

	state_t state_q, state_d;
	opcode_t op_q;
	logic [SEQ_W-1:0] seq_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [LEN_W-1:0] len_q;
	logic connected_q, connected_d;
	logic [SEQ_W-1:0] expected_q, expected_d;
	logic [CNT_W-1:0] drain_cnt_q, drain_cnt_d;

	logic out_valid_q;
	kind_t kind_q, kind_d;
	logic [SEQ_W-1:0] out_seq_q, out_seq_d;
	logic [HANDLE_W-1:0] out_handle_q, out_handle_d;
	logic [LEN_W-1:0] out_len_q, out_len_d;
	logic [SEQ_W-1:0] ack_q, ack_d;
	logic new_conn_q, new_conn_d;
	logic last_q, last_d;
	logic emit;

	logic out_free;
	logic [SEQ_W-1:0] diff;
	cell_cmd_t cmd;
	cell_link_t links [WINDOW+1];
	logic [WINDOW-1:0] hits;

	assign out_free = !out_valid_q || m_axis_tready;
	assign diff = seq_q - expected_q;
	assign links[0] = '0;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		rrw_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.link_in(links[i]),
			.link_out(links[i+1]),
			.hit(hits[i])
		);
	end

	always_comb begin
		state_d = state_q;
		connected_d = connected_q;
		expected_d = expected_q;
		drain_cnt_d = drain_cnt_q;
		emit = 1'b0;
		kind_d = KIND_ACK;
		out_seq_d = '0;
		out_handle_d = '0;
		out_len_d = '0;
		ack_d = expected_q - SEQ_W'(1);
		new_conn_d = 1'b0;
		last_d = 1'b1;
		cmd.key = (state_q == ST_DRAIN) ? expected_q : seq_q;
		cmd.handle = handle_q;
		cmd.len = len_q;
		cmd.wr = 1'b0;
		cmd.del = 1'b0;
		cmd.clr = 1'b0;

		case (state_q)
			ST_EXEC: begin
				if (out_free) begin
					state_d = ST_IDLE;
					if (32'(len_q) <= 32'(MAX_PAYLOAD)) begin
						case (op_q)
							OP_ESTABLISH: begin
								emit = 1'b1;
								kind_d = KIND_ESTABLISHED;
								ack_d = seq_q;
								new_conn_d = !connected_q;
								if (!connected_q) begin
									connected_d = 1'b1;
									expected_d = seq_q + SEQ_W'(1);
									cmd.clr = 1'b1;
								end
							end
							OP_CLOSE: begin
								emit = 1'b1;
								kind_d = KIND_CLOSED;
								ack_d = '0;
								connected_d = 1'b0;
								expected_d = '0;
								cmd.clr = 1'b1;
							end
							OP_PING: begin
								emit = 1'b1;
							end
							OP_DATA: begin
								if (connected_q) begin
									emit = 1'b1;
									if (diff == '0) begin
										kind_d = KIND_DELIVER;
										out_seq_d = seq_q;
										out_handle_d = handle_q;
										out_len_d = len_q;
										ack_d = '0;
										last_d = 1'b0;
										expected_d = expected_q + SEQ_W'(1);
										drain_cnt_d = '0;
										state_d = ST_DRAIN;
									end else begin
										cmd.wr = (diff < SEQ_W'(WINDOW)) && !links[WINDOW].hit;
									end
								end
							end
							default: begin
								state_d = ST_IDLE;
							end
						endcase
					end
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					emit = 1'b1;
					if (links[WINDOW].hit && drain_cnt_q != CNT_W'(WINDOW)) begin
						kind_d = KIND_DELIVER;
						out_seq_d = links[WINDOW].seq;
						out_handle_d = links[WINDOW].handle;
						out_len_d = links[WINDOW].len;
						ack_d = '0;
						last_d = 1'b0;
						cmd.del = 1'b1;
						expected_d = expected_q + SEQ_W'(1);
						drain_cnt_d = drain_cnt_q + CNT_W'(1);
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = state_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			connected_q <= 1'b0;
			expected_q <= '0;
			drain_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE) begin
				if (s_axis_tvalid) begin
					state_q <= ST_EXEC;
				end
			end else begin
				state_q <= state_d;
			end
			connected_q <= connected_d;
			expected_q <= expected_d;
			drain_cnt_q <= drain_cnt_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			op_q <= opcode_t'(s_axis_tuser);
			seq_q <= s_axis_tdata[31:0];
			handle_q <= s_axis_tdata[41:32];
			len_q <= s_axis_tdata[52:42];
		end
		if (emit) begin
			kind_q <= kind_d;
			out_seq_q <= out_seq_d;
			out_handle_q <= out_handle_d;
			out_len_q <= out_len_d;
			ack_q <= ack_d;
			new_conn_q <= new_conn_d;
			last_q <= last_d;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {3'b000, ack_q, out_len_q, out_handle_q, out_seq_q};
	assign m_axis_tuser = {new_conn_q, kind_q};
	assign m_axis_tlast = last_q;

`ifndef NO_ASSERTIONS
	a_unique_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hits))
		else $error("more than one slot holds the same sequence");

	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input open while a request is in progress");

	a_drain_connected: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> connected_q)
		else $error("draining while not connected");

	a_drain_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN && m_axis_tvalid |-> !m_axis_tlast)
		else $error("final result shown while drain still runs");
`endif

endmodule

// ----- hw/rtl/rrw_cell.sv -----
// One hold slot of the receive window, chained to its neighbors.
module rrw_cell (
	input logic clk,
	input logic arst_n,
	input rrw_pkg::cell_cmd_t cmd,
	input rrw_pkg::cell_link_t link_in,
	output rrw_pkg::cell_link_t link_out,
	output logic hit
);
	import rrw_pkg::*;

	logic valid_q;
	logic [SEQ_W-1:0] seq_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [LEN_W-1:0] len_q;
	logic take_free;

	assign hit = valid_q && (seq_q == cmd.key);
	assign take_free = !valid_q && !link_in.free_seen;

	always_comb begin
		link_out.hit = link_in.hit | hit;
		link_out.free_seen = link_in.free_seen | !valid_q;
		link_out.seq = link_in.seq | (hit ? seq_q : '0);
		link_out.handle = link_in.handle | (hit ? handle_q : '0);
		link_out.len = link_in.len | (hit ? len_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clr) begin
			valid_q <= 1'b0;
		end else if (cmd.del && hit) begin
			valid_q <= 1'b0;
		end else if (cmd.wr && take_free) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && take_free && !cmd.clr) begin
			seq_q <= cmd.key;
			handle_q <= cmd.handle;
			len_q <= cmd.len;
		end
	end

endmodule

// ----- dv/tb_top.sv -----
// Testbench for the reorder receive window: predicts every result and checks it.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rrw_pkg::*;

	localparam int WINDOW = 32;

	typedef struct packed {
		kind_t kind;
		logic [SEQ_W-1:0] seq;
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0] len;
		logic [SEQ_W-1:0] ack;
		logic new_conn;
		logic last;
	} window_result_t;

	class rx_window_scoreboard;
		bit connected;
		logic [SEQ_W-1:0] expected_seq;
		bit held_valid[WINDOW];
		logic [SEQ_W-1:0] held_seq[WINDOW];
		logic [HANDLE_W-1:0] held_handle[WINDOW];
		logic [LEN_W-1:0] held_len[WINDOW];
		window_result_t awaited[$];
		int errors;

		function void clear_window();
			connected = 1'b0;
			expected_seq = '0;
			foreach (held_valid[i]) held_valid[i] = 1'b0;
		endfunction

		function int find_held(logic [SEQ_W-1:0] sq);
			for (int i = 0; i < WINDOW; i++) begin
				if (held_valid[i] && held_seq[i] == sq) return i;
			end
			return -1;
		endfunction

		function void add(kind_t k, logic [SEQ_W-1:0] sq, logic [HANDLE_W-1:0] h,
			logic [LEN_W-1:0] ln, logic [SEQ_W-1:0] ackv, logic nc);
			window_result_t r;
			r.kind = k;
			r.seq = sq;
			r.handle = h;
			r.len = ln;
			r.ack = ackv;
			r.new_conn = nc;
			r.last = 1'b0;
			awaited.push_back(r);
		endfunction

		function void note_request(opcode_t op, logic [SEQ_W-1:0] sq, logic [HANDLE_W-1:0] h,
			logic [LEN_W-1:0] ln);
			int n0;
			int s;
			bit fresh;
			logic [SEQ_W-1:0] delta;
			window_result_t r;
			if (ln > MAX_PAYLOAD) return;
			n0 = awaited.size();
			case (op)
				OP_ESTABLISH: begin
					fresh = !connected;
					if (fresh) begin
						clear_window();
						expected_seq = sq + 1;
						connected = 1'b1;
					end
					add(KIND_ESTABLISHED, '0, '0, '0, sq, fresh);
				end
				OP_CLOSE: begin
					clear_window();
					add(KIND_CLOSED, '0, '0, '0, '0, 1'b0);
				end
				OP_PING: add(KIND_ACK, '0, '0, '0, expected_seq - 1, 1'b0);
				default: begin
					if (!connected) return;
					delta = sq - expected_seq;
					if (delta == 0) begin
						add(KIND_DELIVER, sq, h, ln, '0, 1'b0);
						expected_seq++;
						for (int g = 0; g < WINDOW; g++) begin
							s = find_held(expected_seq);
							if (s < 0) break;
							add(KIND_DELIVER, held_seq[s], held_handle[s], held_len[s], '0, 1'b0);
							held_valid[s] = 1'b0;
							expected_seq++;
						end
					end else if (delta < WINDOW && find_held(sq) < 0) begin
						for (int i = 0; i < WINDOW; i++) begin
							if (!held_valid[i]) begin
								held_valid[i] = 1'b1;
								held_seq[i] = sq;
								held_handle[i] = h;
								held_len[i] = ln;
								break;
							end
						end
					end
					add(KIND_ACK, '0, '0, '0, expected_seq - 1, 1'b0);
				end
			endcase
			if (awaited.size() > n0) begin
				r = awaited.pop_back();
				r.last = 1'b1;
				awaited.push_back(r);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void check_result(logic [87:0] d, logic [2:0] u, logic l);
			window_result_t e;
			window_result_t a;
			a.kind = kind_t'(u[1:0]);
			a.new_conn = u[2];
			a.seq = d[31:0];
			a.handle = d[41:32];
			a.len = d[52:42];
			a.ack = d[84:53];
			a.last = l;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t unexpected result: kind=%0d seq=%h handle=%0d len=%0d ack=%h nc=%b last=%b",
						$realtime, a.kind, a.seq, a.handle, a.len, a.ack, a.new_conn, a.last);
				return;
			end
			e = awaited.pop_front();
			if (a !== e) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t mismatch expected: kind=%0d seq=%h handle=%0d len=%0d ack=%h nc=%b last=%b",
						$realtime, e.kind, e.seq, e.handle, e.len, e.ack, e.new_conn, e.last);
					$display("%0t mismatch actual:   kind=%0d seq=%h handle=%0d len=%0d ack=%h nc=%b last=%b",
						$realtime, a.kind, a.seq, a.handle, a.len, a.ack, a.new_conn, a.last);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [87:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic m_axis_tlast;

	rx_window_scoreboard sb;
	bit quiet;
	bit rx_hold_req;
	int counted;

	reorder_receive_window_core #(
		.WINDOW(WINDOW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [LEN_W-1:0] pick_len();
		int c;
		c = $urandom_range(0, 11);
		if (c == 0) return LEN_W'($urandom_range(MAX_PAYLOAD + 1, 2047));
		if (c == 1) return ($urandom_range(0, 1) != 0) ? LEN_W'(MAX_PAYLOAD) : '0;
		return LEN_W'($urandom_range(0, MAX_PAYLOAD));
	endfunction

	task automatic send_request(opcode_t op, logic [SEQ_W-1:0] sq, logic [HANDLE_W-1:0] h,
		logic [LEN_W-1:0] ln);
		counted++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, ln, h, sq};
		s_axis_tuser <= op;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		sb.note_request(op, sq, h, ln);
	endtask

	task automatic data_burst(int n, bit reverse);
		int offs[WINDOW];
		int j;
		int t;
		logic [SEQ_W-1:0] base;
		base = sb.expected_seq;
		for (int i = 0; i < n; i++) offs[i] = reverse ? n - 1 - i : i;
		if (!reverse) begin
			for (int i = n - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				t = offs[i];
				offs[i] = offs[j];
				offs[j] = t;
			end
		end
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 15) == 0) continue;
			send_request(OP_DATA, base + offs[i], HANDLE_W'($urandom_range(0, 1023)), pick_len());
			if ($urandom_range(0, 9) == 0)
				send_request(OP_DATA, base + offs[$urandom_range(0, i)],
					HANDLE_W'($urandom_range(0, 1023)), pick_len());
			if ($urandom_range(0, 11) == 0)
				send_request(OP_PING, $urandom, HANDLE_W'($urandom_range(0, 1023)),
					LEN_W'($urandom_range(0, MAX_PAYLOAD)));
		end
	endtask

	task automatic reconnect();
		logic [SEQ_W-1:0] sq;
		if (sb.connected)
			send_request(OP_CLOSE, $urandom, HANDLE_W'($urandom_range(0, 1023)),
				LEN_W'($urandom_range(0, MAX_PAYLOAD)));
		sq = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40) : $urandom;
		send_request(OP_ESTABLISH, sq, HANDLE_W'($urandom_range(0, 1023)),
			LEN_W'($urandom_range(0, MAX_PAYLOAD)));
	endtask

	initial begin
		int rx_gap;
		m_axis_tready <= 1'b0;
		rx_gap = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
				sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				rx_gap = 300;
			end
			if (rx_gap > 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rx_gap = $urandom_range(1, 16) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		int pick;
		bit hold_done;
		bit pause_done;
		logic [SEQ_W-1:0] e;
		sb = new();
		quiet = 1'b0;
		rx_hold_req = 1'b0;
		hold_done = 1'b0;
		pause_done = 1'b0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_DATA;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_PING, 32'hFFFF_FFFF, 10'd1023, 11'd1300);
		send_request(OP_DATA, 32'h0, 10'd0, 11'd0);
		send_request(OP_CLOSE, 32'h0, 10'd0, 11'd0);
		send_request(OP_ESTABLISH, 32'hFFFF_FFFD, 10'd0, 11'd0);
		send_request(OP_ESTABLISH, 32'h0000_0123, 10'd1023, 11'd1300);
		send_request(OP_DATA, 32'h0000_0000, 10'd1023, 11'd1300);
		send_request(OP_DATA, 32'h0000_001D, 10'h155, 11'h2AA);
		send_request(OP_DATA, 32'h0000_001E, 10'h2AA, 11'd1024);
		send_request(OP_DATA, 32'h0000_0000, 10'd7, 11'd9);
		send_request(OP_DATA, 32'hFFFF_FFFD, 10'd3, 11'd5);
		send_request(OP_DATA, 32'h7FFF_FFFE, 10'd4, 11'd6);
		send_request(OP_DATA, 32'hFFFF_FFFE, 10'd1, 11'd1301);
		send_request(OP_DATA, 32'hFFFF_FFFE, 10'd1023, 11'd2047);
		send_request(OP_PING, 32'h0, 10'd0, 11'd2047);
		send_request(OP_DATA, 32'hFFFF_FFFE, 10'h2AA, 11'h2AA);
		send_request(OP_DATA, 32'hFFFF_FFFF, 10'd0, 11'd0);
		send_request(OP_PING, 32'h0, 10'd0, 11'd0);
		send_request(OP_CLOSE, 32'hFFFF_FFFF, 10'd1023, 11'd1300);
		send_request(OP_PING, 32'h0, 10'd0, 11'd0);
		send_request(OP_ESTABLISH, 32'h7FFF_FFF0, 10'd0, 11'd0);

		data_burst(WINDOW - 1, 1'b1);
		while (counted < 210) begin
			if (counted >= 180) quiet = 1'b1;
			if (!hold_done && counted >= 40) begin
				rx_hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && counted >= 110) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0) @(posedge clk);
				pause_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (!sb.connected || pick < 8) begin
				reconnect();
			end else if (pick < 70) begin
				data_burst(($urandom_range(0, 5) == 0) ? WINDOW - 1 : $urandom_range(1, 8),
					$urandom_range(0, 3) == 0);
			end else if (pick < 85) begin
				send_request(opcode_t'($urandom_range(0, 3)), $urandom,
					HANDLE_W'($urandom_range(0, 1023)), LEN_W'($urandom_range(0, 2047)));
			end else begin
				e = sb.expected_seq;
				case ($urandom_range(0, 3))
					0: e = e - 1 - $urandom_range(0, 40);
					1: e = e + WINDOW + $urandom_range(0, 8);
					2: e = e + WINDOW - 1;
					default: e = e + 32'h8000_0000;
				endcase
				send_request(OP_DATA, e, HANDLE_W'($urandom_range(0, 1023)), pick_len());
			end
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
